// ----- src/wfdt_pkg.sv -----
// wfdt_pkg: shared types, register indexes, direction and recommendation codes
// and the small modulo-three helper for the wall/floor detect and turn pick block.
// No dependencies.
package wfdt_pkg;

   // configuration register indexes
   localparam logic [2:0] REG_FRONT_WALL_THR = 3'd0;
   localparam logic [2:0] REG_SIDE_WALL_THR  = 3'd1;
   localparam logic [2:0] REG_DIAG_WALL_THR  = 3'd2;
   localparam logic [2:0] REG_WALL_HYST      = 3'd3;
   localparam logic [2:0] REG_TAPE_THR       = 3'd4;
   localparam logic [2:0] REG_TAPE_HYST      = 3'd5;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;
   localparam int WallWidth     = 16;
   localparam int TapeWidth     = 12;

   // flag bit positions
   localparam int FLAG_FRONT  = 0;
   localparam int FLAG_LEFT   = 1;
   localparam int FLAG_RIGHT  = 2;
   localparam int FLAG_DLEFT  = 3;
   localparam int FLAG_DRIGHT = 4;
   localparam int FLAG_TFRONT = 5;
   localparam int FLAG_TREAR  = 6;
   localparam int NumFlags    = 7;

   // option mask bits
   localparam logic [3:0] OPT_BACK  = 4'b0001;
   localparam logic [3:0] OPT_FRONT = 4'b0010;
   localparam logic [3:0] OPT_RIGHT = 4'b0100;
   localparam logic [3:0] OPT_LEFT  = 4'b1000;

   // action codes
   localparam logic ACT_SENSE     = 1'b0;
   localparam logic ACT_RECOMMEND = 1'b1;

   // recommendation codes
   localparam logic [2:0] REC_NONE           = 3'd0;
   localparam logic [2:0] REC_BACK           = 3'd1;
   localparam logic [2:0] REC_SMOOTH_LEFT    = 3'd2;
   localparam logic [2:0] REC_SMOOTH_RIGHT   = 3'd3;
   localparam logic [2:0] REC_FRONT_NAV      = 3'd4;
   localparam logic [2:0] REC_FRONT_STRAIGHT = 3'd5;

   typedef logic [NumFlags-1:0] flags_type;

   // one result item
   typedef struct packed {
      flags_type  flags;
      logic [3:0] option_mask;
      logic [1:0] option_count;
      logic [2:0] recommendation;
   } result_type;

   // 32-bit value modulo three: 4 == 1 (mod 3), so base-4 digits are summed
   function automatic logic [1:0] mod3_32(input logic [31:0] value);
      logic [5:0] sum1;
      logic [3:0] sum2;
      logic [2:0] sum3;
      logic [2:0] rem;
      sum1 = '0;
      for (int i = 0; i < 16; i++) begin
         sum1 = sum1 + {4'd0, value[2*i +: 2]};
      end
      sum2 = {2'd0, sum1[5:4]} + {2'd0, sum1[3:2]} + {2'd0, sum1[1:0]};
      sum3 = {1'b0, sum2[3:2]} + {1'b0, sum2[1:0]};
      rem  = (sum3 >= 3'd3) ? (sum3 - 3'd3) : sum3;
      return rem[1:0];
   endfunction

endpackage

// ----- src/wfdt_lane.sv -----
// wfdt_lane: one hysteresis comparator lane, set below threshold and
// released at threshold plus hysteresis. No package dependency.
module wfdt_lane #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0] level,
   input  logic [WIDTH-1:0] threshold,
   input  logic [WIDTH-1:0] hysteresis,
   input  logic             was_set,
   output logic             below
);

   logic [WIDTH:0] release_level;
   logic [WIDTH:0] compare_level;

   // release level one bit wider so it never wraps
   assign release_level = {1'b0, threshold} + {1'b0, hysteresis};
   assign compare_level = was_set ? release_level : {1'b0, threshold};
   assign below         = ({1'b0, level} < compare_level);

endmodule

// ----- src/wfdt_merge.sv -----
// wfdt_merge: combines the lane results into the new flags, builds the
// option mask and picks a turn. Depends on wfdt_pkg.
module wfdt_merge (
   input  logic                action,
   input  logic [7:0]          lane_below,
   input  wfdt_pkg::flags_type flags_cur,
   input  logic [31:0]         random_word,
   output wfdt_pkg::flags_type flags_next,
   output wfdt_pkg::result_type result
);
   import wfdt_pkg::*;

   flags_type  sensed;
   logic       free_front;
   logic       free_right;
   logic       free_left;
   logic [1:0] count;
   logic [1:0] pick;
   logic [1:0] right_pos;
   logic [2:0] rec;

   // lanes 0 and 1 are the two front sensors, both must see the wall
   always_comb begin
      sensed              = '0;
      sensed[FLAG_FRONT]  = lane_below[0] & lane_below[1];
      sensed[FLAG_LEFT]   = lane_below[2];
      sensed[FLAG_RIGHT]  = lane_below[3];
      sensed[FLAG_DLEFT]  = lane_below[4];
      sensed[FLAG_DRIGHT] = lane_below[5];
      sensed[FLAG_TFRONT] = lane_below[6];
      sensed[FLAG_TREAR]  = lane_below[7];
   end

   assign flags_next = (action == ACT_SENSE) ? sensed : flags_cur;

   // free directions in pick order front, right, left
   assign free_front = ~flags_next[FLAG_FRONT];
   assign free_right = ~flags_next[FLAG_RIGHT];
   assign free_left  = ~flags_next[FLAG_LEFT];
   assign count      = {1'b0, free_front} + {1'b0, free_right} + {1'b0, free_left};
   assign right_pos  = {1'b0, free_front};

   // random word modulo count
   always_comb begin
      case (count)
         2'd2:    pick = {1'b0, random_word[0]};
         2'd3:    pick = mod3_32(random_word);
         default: pick = 2'd0;
      endcase
   end

   // map the picked list entry to a recommendation
   always_comb begin
      if (action == ACT_SENSE) begin
         rec = REC_NONE;
      end else if (count == 2'd0) begin
         rec = REC_BACK;
      end else if (free_front && (pick == 2'd0)) begin
         rec = (flags_next[FLAG_LEFT] | flags_next[FLAG_RIGHT]) ?
               REC_FRONT_NAV : REC_FRONT_STRAIGHT;
      end else if (free_right && (pick == right_pos)) begin
         rec = REC_SMOOTH_RIGHT;
      end else begin
         rec = REC_SMOOTH_LEFT;
      end
   end

   assign result.flags          = flags_next;
   assign result.option_mask    = OPT_BACK | (free_front ? OPT_FRONT : 4'b0000)
                                  | (free_right ? OPT_RIGHT : 4'b0000)
                                  | (free_left ? OPT_LEFT : 4'b0000);
   assign result.option_count   = count;
   assign result.recommendation = rec;

endmodule

// ----- src/wall_floor_detect_and_turn_pick.sv -----
// wall_floor_detect_and_turn_pick: eight comparator lanes, a merge stage,
// the flag register and the output register. Depends on wfdt_pkg, wfdt_lane,
// wfdt_merge.
// An input transfer sets rsp_valid in the following cycle.
// Throughput: one item per cycle while rsp_stall is low, set by the single
// output register, which is refilled in the cycle it is taken.
// Reset: clears all detection flags and the output valid, and loads the
// threshold registers with 150, 120, 150, 20, 1500 and 200.
module wall_floor_detect_and_turn_pick (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [wfdt_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [wfdt_pkg::CsrDataWidth-1:0]  csr_wdata,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_front_left_mm,
   input  logic [15:0] req_front_right_mm,
   input  logic [15:0] req_left_side_mm,
   input  logic [15:0] req_right_side_mm,
   input  logic [15:0] req_left_diag_mm,
   input  logic [15:0] req_right_diag_mm,
   input  logic [11:0] req_floor_front_level,
   input  logic [11:0] req_floor_rear_level,
   input  logic [31:0] req_random_word,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_wall_ahead,
   output logic        rsp_wall_on_left,
   output logic        rsp_wall_on_right,
   output logic        rsp_left_diag_wall,
   output logic        rsp_right_diag_wall,
   output logic        rsp_tape_front,
   output logic        rsp_tape_rear,
   output logic [3:0]  rsp_option_mask,
   output logic [1:0]  rsp_option_count,
   output logic [2:0]  rsp_recommendation
);
   import wfdt_pkg::*;

   logic [WallWidth-1:0] front_thr_ff, front_thr_in;
   logic [WallWidth-1:0] side_thr_ff, side_thr_in;
   logic [WallWidth-1:0] diag_thr_ff, diag_thr_in;
   logic [WallWidth-1:0] wall_hyst_ff, wall_hyst_in;
   logic [TapeWidth-1:0] tape_thr_ff, tape_thr_in;
   logic [TapeWidth-1:0] tape_hyst_ff, tape_hyst_in;

   flags_type  flags_ff, flags_in;
   flags_type  flags_next;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;
   result_type result;
   logic [7:0] lane_below;
   logic       csr_write;
   logic       req_xfer;

   // configuration register writes, always ready
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      front_thr_in = front_thr_ff;
      side_thr_in  = side_thr_ff;
      diag_thr_in  = diag_thr_ff;
      wall_hyst_in = wall_hyst_ff;
      tape_thr_in  = tape_thr_ff;
      tape_hyst_in = tape_hyst_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_FRONT_WALL_THR: front_thr_in = csr_wdata;
            REG_SIDE_WALL_THR:  side_thr_in  = csr_wdata;
            REG_DIAG_WALL_THR:  diag_thr_in  = csr_wdata;
            REG_WALL_HYST:      wall_hyst_in = csr_wdata;
            REG_TAPE_THR:       tape_thr_in  = csr_wdata[TapeWidth-1:0];
            REG_TAPE_HYST:      tape_hyst_in = csr_wdata[TapeWidth-1:0];
            default: ;
         endcase
      end
   end

   // comparator lanes, front pair shares the front flag
   wfdt_lane #(.WIDTH(WallWidth)) u_lane_fl (
      .level(req_front_left_mm), .threshold(front_thr_ff), .hysteresis(wall_hyst_ff),
      .was_set(flags_ff[FLAG_FRONT]), .below(lane_below[0]));
   wfdt_lane #(.WIDTH(WallWidth)) u_lane_fr (
      .level(req_front_right_mm), .threshold(front_thr_ff), .hysteresis(wall_hyst_ff),
      .was_set(flags_ff[FLAG_FRONT]), .below(lane_below[1]));
   wfdt_lane #(.WIDTH(WallWidth)) u_lane_ls (
      .level(req_left_side_mm), .threshold(side_thr_ff), .hysteresis(wall_hyst_ff),
      .was_set(flags_ff[FLAG_LEFT]), .below(lane_below[2]));
   wfdt_lane #(.WIDTH(WallWidth)) u_lane_rs (
      .level(req_right_side_mm), .threshold(side_thr_ff), .hysteresis(wall_hyst_ff),
      .was_set(flags_ff[FLAG_RIGHT]), .below(lane_below[3]));
   wfdt_lane #(.WIDTH(WallWidth)) u_lane_ld (
      .level(req_left_diag_mm), .threshold(diag_thr_ff), .hysteresis(wall_hyst_ff),
      .was_set(flags_ff[FLAG_DLEFT]), .below(lane_below[4]));
   wfdt_lane #(.WIDTH(WallWidth)) u_lane_rd (
      .level(req_right_diag_mm), .threshold(diag_thr_ff), .hysteresis(wall_hyst_ff),
      .was_set(flags_ff[FLAG_DRIGHT]), .below(lane_below[5]));
   wfdt_lane #(.WIDTH(TapeWidth)) u_lane_tf (
      .level(req_floor_front_level), .threshold(tape_thr_ff), .hysteresis(tape_hyst_ff),
      .was_set(flags_ff[FLAG_TFRONT]), .below(lane_below[6]));
   wfdt_lane #(.WIDTH(TapeWidth)) u_lane_tr (
      .level(req_floor_rear_level), .threshold(tape_thr_ff), .hysteresis(tape_hyst_ff),
      .was_set(flags_ff[FLAG_TREAR]), .below(lane_below[7]));

   // merge lanes, build options and pick
   wfdt_merge u_merge (
      .action(req_action),
      .lane_below(lane_below),
      .flags_cur(flags_ff),
      .random_word(req_random_word),
      .flags_next(flags_next),
      .result(result)
   );

   // input transfer whenever the output register is empty or being drained
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;

   always_comb begin
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_xfer) begin
         flags_in     = flags_next;
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_thr_ff <= 16'd150;
         side_thr_ff  <= 16'd120;
         diag_thr_ff  <= 16'd150;
         wall_hyst_ff <= 16'd20;
         tape_thr_ff  <= 12'd1500;
         tape_hyst_ff <= 12'd200;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_thr_ff <= front_thr_in;
         side_thr_ff  <= side_thr_in;
         diag_thr_ff  <= diag_thr_in;
         wall_hyst_ff <= wall_hyst_in;
         tape_thr_ff  <= tape_thr_in;
         tape_hyst_ff <= tape_hyst_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_wall_ahead      = rsp_data_ff.flags[FLAG_FRONT];
   assign rsp_wall_on_left    = rsp_data_ff.flags[FLAG_LEFT];
   assign rsp_wall_on_right   = rsp_data_ff.flags[FLAG_RIGHT];
   assign rsp_left_diag_wall  = rsp_data_ff.flags[FLAG_DLEFT];
   assign rsp_right_diag_wall = rsp_data_ff.flags[FLAG_DRIGHT];
   assign rsp_tape_front      = rsp_data_ff.flags[FLAG_TFRONT];
   assign rsp_tape_rear       = rsp_data_ff.flags[FLAG_TREAR];
   assign rsp_option_mask     = rsp_data_ff.option_mask;
   assign rsp_option_count    = rsp_data_ff.option_count;
   assign rsp_recommendation  = rsp_data_ff.recommendation;

endmodule

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for wall_floor_detect_and_turn_pick, with a local
// model of the hysteresis flags and turn pick, random idling on both channels.
// Depends on wfdt_pkg and the block's RTL only.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import wfdt_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_CAP   = 40;
   localparam logic [2:0] REG_UNUSED_6 = 3'd6;
   localparam logic [2:0] REG_UNUSED_7 = 3'd7;

   typedef enum logic [1:0] {TURN_FRONT, TURN_RIGHT, TURN_LEFT} turn_dir_type;

   // one input transfer
   typedef struct {
      logic        action;
      logic [15:0] front_left;
      logic [15:0] front_right;
      logic [15:0] left_side;
      logic [15:0] right_side;
      logic [15:0] left_diag;
      logic [15:0] right_diag;
      logic [11:0] floor_front;
      logic [11:0] floor_rear;
      logic [31:0] rnd_word;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = ACT_SENSE;
   logic [15:0] req_front_left_mm = '0;
   logic [15:0] req_front_right_mm = '0;
   logic [15:0] req_left_side_mm = '0;
   logic [15:0] req_right_side_mm = '0;
   logic [15:0] req_left_diag_mm = '0;
   logic [15:0] req_right_diag_mm = '0;
   logic [11:0] req_floor_front_level = '0;
   logic [11:0] req_floor_rear_level = '0;
   logic [31:0] req_random_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_wall_ahead;
   logic        rsp_wall_on_left;
   logic        rsp_wall_on_right;
   logic        rsp_left_diag_wall;
   logic        rsp_right_diag_wall;
   logic        rsp_tape_front;
   logic        rsp_tape_rear;
   logic [3:0]  rsp_option_mask;
   logic [1:0]  rsp_option_count;
   logic [2:0]  rsp_recommendation;

   wall_floor_detect_and_turn_pick dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_front_left_mm(req_front_left_mm), .req_front_right_mm(req_front_right_mm),
      .req_left_side_mm(req_left_side_mm), .req_right_side_mm(req_right_side_mm),
      .req_left_diag_mm(req_left_diag_mm), .req_right_diag_mm(req_right_diag_mm),
      .req_floor_front_level(req_floor_front_level),
      .req_floor_rear_level(req_floor_rear_level),
      .req_random_word(req_random_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_wall_ahead(rsp_wall_ahead), .rsp_wall_on_left(rsp_wall_on_left),
      .rsp_wall_on_right(rsp_wall_on_right), .rsp_left_diag_wall(rsp_left_diag_wall),
      .rsp_right_diag_wall(rsp_right_diag_wall), .rsp_tape_front(rsp_tape_front),
      .rsp_tape_rear(rsp_tape_rear), .rsp_option_mask(rsp_option_mask),
      .rsp_option_count(rsp_option_count), .rsp_recommendation(rsp_recommendation)
   );

   // model copy of registers and flags
   logic [15:0] cfg_front_thr = 16'd150;
   logic [15:0] cfg_side_thr  = 16'd120;
   logic [15:0] cfg_diag_thr  = 16'd150;
   logic [15:0] cfg_wall_hys  = 16'd20;
   logic [11:0] cfg_tape_thr  = 12'd1500;
   logic [11:0] cfg_tape_hys  = 12'd200;
   flags_type   det_flags     = '0;

   result_type  pending_outcomes[$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int readings_sent  = 0;
   int outcomes_seen  = 0;
   int csr_writes     = 0;
   int rec_tally[8];
   int burst_left     = 0;
   bit gaps_enabled   = 1'b1;
   int hold_cycles_req = 0;
   int hold_left      = 0;
   int stretch_left   = 0;
   int stall_mode     = 0;

   string flag_names[NumFlags] = '{"wall_ahead", "wall_on_left", "wall_on_right",
      "left_diag_wall", "right_diag_wall", "tape_front", "tape_rear"};

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_outcomes.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch %s: got %0h expected %0h (cycle %0d)",
                  what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // set below threshold, released at threshold plus hysteresis, one bit wider
   function automatic logic below_level(input logic [15:0] v, input logic [15:0] thr,
                                        input logic [15:0] hys, input logic was);
      logic [16:0] release_lvl;
      release_lvl = {1'b0, thr} + {1'b0, hys};
      return was ? ({1'b0, v} < release_lvl) : (v < thr);
   endfunction

   // model: update flags or pick a turn, queue the expected result
   task automatic predict_outcome(input reading_type it);
      result_type r;
      flags_type  nf;
      turn_dir_type free_list[3];
      logic [1:0] n;
      logic [31:0] pick;
      if (it.action == ACT_SENSE) begin
         nf[FLAG_FRONT] =
            below_level(it.front_left, cfg_front_thr, cfg_wall_hys, det_flags[FLAG_FRONT]) &&
            below_level(it.front_right, cfg_front_thr, cfg_wall_hys, det_flags[FLAG_FRONT]);
         nf[FLAG_LEFT] =
            below_level(it.left_side, cfg_side_thr, cfg_wall_hys, det_flags[FLAG_LEFT]);
         nf[FLAG_RIGHT] =
            below_level(it.right_side, cfg_side_thr, cfg_wall_hys, det_flags[FLAG_RIGHT]);
         nf[FLAG_DLEFT] =
            below_level(it.left_diag, cfg_diag_thr, cfg_wall_hys, det_flags[FLAG_DLEFT]);
         nf[FLAG_DRIGHT] =
            below_level(it.right_diag, cfg_diag_thr, cfg_wall_hys, det_flags[FLAG_DRIGHT]);
         nf[FLAG_TFRONT] = below_level({4'd0, it.floor_front}, {4'd0, cfg_tape_thr},
                                       {4'd0, cfg_tape_hys}, det_flags[FLAG_TFRONT]);
         nf[FLAG_TREAR] = below_level({4'd0, it.floor_rear}, {4'd0, cfg_tape_thr},
                                      {4'd0, cfg_tape_hys}, det_flags[FLAG_TREAR]);
         det_flags = nf;
      end
      // free directions in order front, right, left
      r.flags = det_flags;
      r.option_mask = OPT_BACK;
      n = 2'd0;
      if (!det_flags[FLAG_FRONT]) begin
         r.option_mask |= OPT_FRONT;
         free_list[n] = TURN_FRONT;
         n++;
      end
      if (!det_flags[FLAG_RIGHT]) begin
         r.option_mask |= OPT_RIGHT;
         free_list[n] = TURN_RIGHT;
         n++;
      end
      if (!det_flags[FLAG_LEFT]) begin
         r.option_mask |= OPT_LEFT;
         free_list[n] = TURN_LEFT;
         n++;
      end
      r.option_count = n;
      r.recommendation = REC_NONE;
      if (it.action == ACT_RECOMMEND) begin
         if (n == 2'd0) begin
            r.recommendation = REC_BACK;
         end else begin
            pick = it.rnd_word % {30'd0, n};
            case (free_list[pick[1:0]])
               TURN_LEFT:  r.recommendation = REC_SMOOTH_LEFT;
               TURN_RIGHT: r.recommendation = REC_SMOOTH_RIGHT;
               default: begin
                  if (det_flags[FLAG_LEFT] || det_flags[FLAG_RIGHT])
                     r.recommendation = REC_FRONT_NAV;
                  else
                     r.recommendation = REC_FRONT_STRAIGHT;
               end
            endcase
         end
      end
      rec_tally[r.recommendation]++;
      pending_outcomes.push_back(r);
   endtask

   // offer one reading, hold it until the transfer, then maybe open a gap
   task automatic drive_reading(input reading_type it);
      int gap;
      req_valid             <= 1'b1;
      req_action            <= it.action;
      req_front_left_mm     <= it.front_left;
      req_front_right_mm    <= it.front_right;
      req_left_side_mm      <= it.left_side;
      req_right_side_mm     <= it.right_side;
      req_left_diag_mm      <= it.left_diag;
      req_right_diag_mm     <= it.right_diag;
      req_floor_front_level <= it.floor_front;
      req_floor_rear_level  <= it.floor_rear;
      req_random_word       <= it.rnd_word;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_outcome(it);
      readings_sent++;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         if (gaps_enabled) gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic stop_offering();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait until every queued result is back, plus the output stage latency
   task automatic settle_block();
      stop_offering();
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         REG_FRONT_WALL_THR: cfg_front_thr = data;
         REG_SIDE_WALL_THR:  cfg_side_thr  = data;
         REG_DIAG_WALL_THR:  cfg_diag_thr  = data;
         REG_WALL_HYST:      cfg_wall_hys  = data;
         REG_TAPE_THR:       cfg_tape_thr  = data[11:0];
         REG_TAPE_HYST:      cfg_tape_hys  = data[11:0];
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic reading_type sense_item(input int fl, input int fr, input int ls,
                                              input int rs, input int ld, input int rd,
                                              input int tf, input int tr);
      reading_type it;
      it.action      = ACT_SENSE;
      it.front_left  = 16'(fl);
      it.front_right = 16'(fr);
      it.left_side   = 16'(ls);
      it.right_side  = 16'(rs);
      it.left_diag   = 16'(ld);
      it.right_diag  = 16'(rd);
      it.floor_front = 12'(tf);
      it.floor_rear  = 12'(tr);
      it.rnd_word    = $urandom;
      return it;
   endfunction

   // recommend carries readings too; they must have no effect
   function automatic reading_type recommend_item(input logic [31:0] word);
      reading_type it;
      it = sense_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
      it.action   = ACT_RECOMMEND;
      it.rnd_word = word;
      return it;
   endfunction

   // reading clustered around the set and release levels
   function automatic int near_level(input int thr, input int hys, input int maxv);
      int v;
      case ($urandom_range(0, 7))
         0: v = $urandom_range(0, maxv);
         1: v = 0;
         2: v = maxv;
         default: v = thr + int'($urandom_range(0, hys + 8)) - 4;
      endcase
      if (v < 0) v = 0;
      if (v > maxv) v = maxv;
      return v;
   endfunction

   function automatic reading_type random_reading();
      reading_type it;
      int fl, fr;
      if ($urandom_range(0, 9) < 4) return recommend_item($urandom);
      fl = near_level(cfg_front_thr, cfg_wall_hys, 65535);
      fr = ($urandom_range(0, 1) != 0) ? fl : near_level(cfg_front_thr, cfg_wall_hys, 65535);
      it = sense_item(fl, fr,
                      near_level(cfg_side_thr, cfg_wall_hys, 65535),
                      near_level(cfg_side_thr, cfg_wall_hys, 65535),
                      near_level(cfg_diag_thr, cfg_wall_hys, 65535),
                      near_level(cfg_diag_thr, cfg_wall_hys, 65535),
                      near_level(cfg_tape_thr, cfg_tape_hys, 4095),
                      near_level(cfg_tape_thr, cfg_tape_hys, 4095));
      return it;
   endfunction

   // receiver stall pattern, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_cycles_req != 0) begin
         hold_left = hold_cycles_req;
         hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stretch_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stretch_left = $urandom_range(5, 60);
         end
         stretch_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin : result_check
      result_type got, want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got.flags[FLAG_FRONT]  = rsp_wall_ahead;
         got.flags[FLAG_LEFT]   = rsp_wall_on_left;
         got.flags[FLAG_RIGHT]  = rsp_wall_on_right;
         got.flags[FLAG_DLEFT]  = rsp_left_diag_wall;
         got.flags[FLAG_DRIGHT] = rsp_right_diag_wall;
         got.flags[FLAG_TFRONT] = rsp_tape_front;
         got.flags[FLAG_TREAR]  = rsp_tape_rear;
         got.option_mask        = rsp_option_mask;
         got.option_count       = rsp_option_count;
         got.recommendation     = rsp_recommendation;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(got), 0);
         end else begin
            want = pending_outcomes.pop_front();
            outcomes_seen++;
            for (int i = 0; i < NumFlags; i++)
               if (got.flags[i] !== want.flags[i])
                  report_mismatch(flag_names[i], 32'(got.flags[i]), 32'(want.flags[i]));
            if (got.option_mask !== want.option_mask)
               report_mismatch("option_mask", 32'(got.option_mask),
                               32'(want.option_mask));
            if (got.option_count !== want.option_count)
               report_mismatch("option_count", 32'(got.option_count),
                               32'(want.option_count));
            if (got.recommendation !== want.recommendation)
               report_mismatch("recommendation", 32'(got.recommendation),
                               32'(want.recommendation));
         end
      end
   end

   // reset levels: set, hold, release at exact boundaries, every pick
   task automatic test_reset_levels_and_picks();
      drive_reading(sense_item(0, 0, 0, 0, 0, 0, 0, 0));
      drive_reading(recommend_item(32'd0));
      drive_reading(sense_item(169, 169, 139, 139, 169, 169, 1699, 1699));
      drive_reading(sense_item(170, 170, 140, 140, 170, 170, 1700, 1700));
      drive_reading(recommend_item(32'd0));
      drive_reading(recommend_item(32'd1));
      drive_reading(recommend_item(32'd2));
      drive_reading(recommend_item(32'hFFFF_FFFF));
      drive_reading(sense_item(150, 150, 120, 120, 150, 150, 1500, 1500));
      drive_reading(sense_item(149, 149, 119, 119, 149, 149, 1499, 1499));
      // one front sensor far away clears front; right wall stays
      drive_reading(sense_item(0, 65535, 65535, 0, 65535, 0, 4095, 0));
      drive_reading(recommend_item(32'd1));
      drive_reading(recommend_item(32'd0));
      // only right is free
      drive_reading(sense_item(0, 0, 0, 65535, 0, 65535, 0, 4095));
      drive_reading(recommend_item(32'h8000_0000));
      drive_reading(sense_item(160, 65535, 0, 0, 0, 0, 0, 0));
      drive_reading(recommend_item(32'h5555_5555));
      drive_reading(sense_item(65535, 65535, 65535, 65535, 65535, 65535, 4095, 4095));
      drive_reading(recommend_item(32'hAAAA_AAAA));
      settle_block();
   endtask

   // all registers at zero, then at full scale, then unused indexes
   task automatic test_register_extremes();
      settle_block();
      for (int r = REG_FRONT_WALL_THR; r <= REG_TAPE_HYST; r++)
         write_register(3'(r), 16'h0000);
      drive_reading(sense_item(0, 0, 0, 0, 0, 0, 0, 0));
      drive_reading(recommend_item($urandom));
      drive_reading(random_reading());
      settle_block();
      for (int r = REG_FRONT_WALL_THR; r <= REG_TAPE_HYST; r++)
         write_register(3'(r), 16'hFFFF);
      drive_reading(sense_item(65534, 65534, 65534, 65534, 65534, 65534, 4094, 4094));
      drive_reading(sense_item(65535, 65535, 65535, 65535, 65535, 65535, 4095, 4095));
      drive_reading(recommend_item($urandom));
      settle_block();
      write_register(REG_UNUSED_6, 16'($urandom));
      write_register(REG_UNUSED_7, 16'($urandom));
      drive_reading(random_reading());
      settle_block();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      settle_block();
      gaps_enabled = 1'b0;
      hold_cycles_req = 250;
      repeat (40) drive_reading(random_reading());
      gaps_enabled = 1'b1;
      settle_block();
   endtask

   // random register settings, about 1000 readings around their levels
   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         settle_block();
         write_register(REG_FRONT_WALL_THR,
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)));
         write_register(REG_SIDE_WALL_THR,
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)));
         write_register(REG_DIAG_WALL_THR,
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)));
         write_register(REG_WALL_HYST,
                        ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60)));
         // upper bits of the tape writes are random and must be dropped
         write_register(REG_TAPE_THR, 16'($urandom));
         write_register(REG_TAPE_HYST,
                        {4'($urandom), 12'($urandom_range(0, 300))});
         gaps_enabled = (phase != 2);
         repeat (200) drive_reading(random_reading());
      end
      gaps_enabled = 1'b1;
      settle_block();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_levels_and_picks();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();
      settle_block();
      repeat (5) @(posedge clock);
      if (pending_outcomes.size() != 0)
         report_mismatch("results never returned", pending_outcomes.size(), 0);
      $display("covered %0d readings, %0d results, %0d register writes",
               readings_sent, outcomes_seen, csr_writes);
      $display("picks: back %0d left %0d right %0d front-nav %0d front-straight %0d",
               rec_tally[REC_BACK], rec_tally[REC_SMOOTH_LEFT], rec_tally[REC_SMOOTH_RIGHT],
               rec_tally[REC_FRONT_NAV], rec_tally[REC_FRONT_STRAIGHT]);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- sim.f -----
src/wfdt_pkg.sv
src/wfdt_lane.sv
src/wfdt_merge.sv
src/wall_floor_detect_and_turn_pick.sv
sim/tb_top.sv
